// ----- src/glos_pkg.sv -----
// Shared widths, codes and types for the grid line-of-sight unit.
`default_nettype none

package glos_pkg;

  localparam int ROW_W   = 6;
  localparam int COL_W   = 8;
  localparam int CODE_W  = 4;
  localparam int COORD_W = 8;
  localparam int DELTA_W = COORD_W + 1;
  localparam int ACC_W   = 18;

  localparam int MAP_ROWS_DEF = 64;
  localparam int MAP_COLS_DEF = 256;

  localparam logic [CODE_W-1:0] THRESH_RESET = 4'd8;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef logic signed [ACC_W-1:0] acc_t;

  // Outcome of one accumulator step.
  typedef struct packed {
    logic minor;  // take a step on the minor axis
    logic extra;  // minor step happens before the major step: extra cell read
    acc_t acc;    // accumulator after the step
  } step_t;

endpackage

`default_nettype wire

// ----- src/glos_if.sv -----
// Command and result channel interfaces for the grid line-of-sight unit.
`default_nettype none

interface glos_cmd_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [glos_pkg::ROW_W-1:0]  from_row;
  logic [glos_pkg::COL_W-1:0]  from_col;
  logic [glos_pkg::ROW_W-1:0]  to_row;
  logic [glos_pkg::COL_W-1:0]  to_col;
  logic [glos_pkg::CODE_W-1:0] cell_code;

  modport source (output valid, action, from_row, from_col, to_row, to_col, cell_code,
                  input ready);
  modport sink (input valid, action, from_row, from_col, to_row, to_col, cell_code,
                output ready);
endinterface

interface glos_res_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface

`default_nettype wire

// ----- src/glos_map.sv -----
// Map cell memory: one write port, one registered read port, bounds checks.
`default_nettype none

module glos_map #(
  parameter int MAP_ROWS = glos_pkg::MAP_ROWS_DEF,
  parameter int MAP_COLS = glos_pkg::MAP_COLS_DEF
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [glos_pkg::COORD_W-1:0] wr_row,
  input  logic [glos_pkg::COORD_W-1:0] wr_col,
  input  logic [glos_pkg::CODE_W-1:0]  wr_code,
  input  logic [glos_pkg::COORD_W-1:0] rd_row,
  input  logic [glos_pkg::COORD_W-1:0] rd_col,
  output logic [glos_pkg::CODE_W-1:0]  rd_code,
  output logic                        rd_hit
);

  localparam int DEPTH = MAP_ROWS * MAP_COLS;
  localparam int AW    = $clog2(DEPTH);

  logic [glos_pkg::CODE_W-1:0] mem [DEPTH];

  logic          wr_in, rd_in;
  logic [AW-1:0] wr_addr, rd_addr;

  assign wr_in = (32'(wr_row) < MAP_ROWS) && (32'(wr_col) < MAP_COLS);
  assign rd_in = (32'(rd_row) < MAP_ROWS) && (32'(rd_col) < MAP_COLS);

  // Cells off the map read as open; keep the address in range then.
  assign wr_addr = AW'(32'(wr_row) * MAP_COLS + 32'(wr_col));
  assign rd_addr = rd_in ? AW'(32'(rd_row) * MAP_COLS + 32'(rd_col)) : '0;

  always_ff @(posedge clk) begin
    if (we && wr_in) begin
      mem[wr_addr] <= wr_code;
    end
  end

  always_ff @(posedge clk) begin
    rd_code <= mem[rd_addr];
    rd_hit  <= rd_in;
  end

endmodule

`default_nettype wire

// ----- src/glos_step.sv -----
// Shared accumulator unit: add, compare against the midpoint, wrap.
`default_nettype none

module glos_step (
  input  glos_pkg::acc_t  acc,
  input  glos_pkg::acc_t  addend,
  input  glos_pkg::acc_t  half,
  input  glos_pkg::acc_t  full,
  output glos_pkg::step_t step
);

  glos_pkg::acc_t sum;

  assign sum = acc + addend;

  always_comb begin
    step.minor = (sum >= half);
    step.extra = (sum > half);
    step.acc   = step.minor ? sum - full : sum;
  end

endmodule

`default_nettype wire

// ----- src/grid_line_of_sight_unit.sv -----
// Top level: command sequencer for map writes and line-of-sight traces.
//
//   channel  dir  handshake        payload
//   cmd      in   valid/ready      action, from_row, from_col, to_row, to_col, cell_code
//   res      out  valid/ready      visible
//   cfg      in   cfg_we           cfg_wdata (closed threshold)
//
// A write passes through the write state. A query of neighboring cells ends at
// setup; any other query reads cells along the line one at a time through the
// single map read port, with an extra cell read per minor step before a major step.
// Reset (rst, synchronous) clears the sequencer and output valid and sets the
// threshold to 8; map contents are not cleared. A result waiting on res holds
// the sequencer in its last state; cmd is taken again once the result is loaded.
`default_nettype none

module grid_line_of_sight_unit #(
  parameter int MAP_ROWS = glos_pkg::MAP_ROWS_DEF,
  parameter int MAP_COLS = glos_pkg::MAP_COLS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  glos_cmd_if.sink                    cmd,
  glos_res_if.source                  res,
  input  logic                        cfg_we,
  input  logic [glos_pkg::CODE_W-1:0] cfg_wdata
);

  localparam int CW = glos_pkg::COORD_W;
  localparam int DW = glos_pkg::DELTA_W;
  localparam int AW = glos_pkg::ACC_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WRITE = 4'd1;
  localparam logic [3:0] S_SETUP = 4'd2;
  localparam logic [3:0] S_MUL1  = 4'd3;
  localparam logic [3:0] S_MUL2  = 4'd4;
  localparam logic [3:0] S_INIT  = 4'd5;
  localparam logic [3:0] S_LOOP  = 4'd6;
  localparam logic [3:0] S_CHK1  = 4'd7;
  localparam logic [3:0] S_RD2   = 4'd8;
  localparam logic [3:0] S_CHK2  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state;
  logic [glos_pkg::CODE_W-1:0] thresh;

  logic [glos_pkg::ROW_W-1:0]  f_row, t_row;
  logic [glos_pkg::COL_W-1:0]  f_col, t_col;
  logic [glos_pkg::CODE_W-1:0] code;

  logic          rows_major, sma_neg, smi_neg, smi_zero;
  logic [CW-1:0] dma_abs, dmi_abs;
  logic [CW-1:0] ma, mi, ma1;
  glos_pkg::acc_t half, full, slope, acc;
  logic          vis_res;
  logic          out_valid, out_vis;

  // setup arithmetic
  logic signed [DW-1:0] dr, dc;
  logic [CW-1:0]        adr, adc, ma0;
  logic                 adj, rmaj;

  assign dr  = $signed({3'b000, t_row}) - $signed({3'b000, f_row});
  assign dc  = $signed({1'b0, t_col}) - $signed({1'b0, f_col});
  assign adr = dr[DW-1] ? CW'(-dr) : dr[CW-1:0];
  assign adc = dc[DW-1] ? CW'(-dc) : dc[CW-1:0];
  assign adj = (dr >= -9'sd1) && (dr <= 9'sd1) && (dc >= -9'sd1) && (dc <= 9'sd1);
  assign rmaj = (adc < adr);
  assign ma0  = rmaj ? {2'b00, f_row} : f_col;

  // one multiplier, used twice during setup
  logic [CW-1:0]   mul_a;
  logic [2*CW-1:0] prod;

  assign mul_a = (state == S_MUL1) ? dma_abs : dmi_abs;
  assign prod  = mul_a * dmi_abs;

  // coordinate advance
  logic [CW-1:0] ma_adv, mi_adv;

  assign ma_adv = sma_neg ? ma - 1'b1 : ma + 1'b1;
  assign mi_adv = smi_zero ? mi : (smi_neg ? mi - 1'b1 : mi + 1'b1);

  // accumulator unit
  glos_pkg::acc_t  addend;
  glos_pkg::step_t step;

  assign addend = (state == S_INIT) ? '0 : slope;

  glos_step u_step (
    .acc    (acc),
    .addend (addend),
    .half   (half),
    .full   (full),
    .step   (step)
  );

  // map memory
  logic [CW-1:0]               rd_row, rd_col;
  logic [glos_pkg::CODE_W-1:0] rd_code;
  logic                        rd_hit, blk;

  assign rd_row = rows_major ? ma : mi;
  assign rd_col = rows_major ? mi : ma;
  assign blk    = rd_hit && (rd_code >= thresh);

  glos_map #(
    .MAP_ROWS (MAP_ROWS),
    .MAP_COLS (MAP_COLS)
  ) u_map (
    .clk     (clk),
    .we      (state == S_WRITE),
    .wr_row  ({2'b00, f_row}),
    .wr_col  (f_col),
    .wr_code (code),
    .rd_row  (rd_row),
    .rd_col  (rd_col),
    .rd_code (rd_code),
    .rd_hit  (rd_hit)
  );

  assign cmd.ready   = (state == S_IDLE);
  assign res.valid   = out_valid;
  assign res.visible = out_vis;

  logic load_out;
  assign load_out = (state == S_DONE) && (!out_valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= glos_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      thresh <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_vis <= vis_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            f_row <= cmd.from_row;
            f_col <= cmd.from_col;
            t_row <= cmd.to_row;
            t_col <= cmd.to_col;
            code  <= cmd.cell_code;
            state <= (cmd.action == glos_pkg::ACT_QUERY) ? S_SETUP : S_WRITE;
          end
        end
        S_WRITE: begin
          state <= S_IDLE;
        end
        S_SETUP: begin
          if (adj) begin
            vis_res <= 1'b1;
            state   <= S_DONE;
          end else begin
            rows_major <= rmaj;
            dma_abs    <= rmaj ? adr : adc;
            dmi_abs    <= rmaj ? adc : adr;
            sma_neg    <= rmaj ? dr[DW-1] : dc[DW-1];
            smi_neg    <= rmaj ? dc[DW-1] : dr[DW-1];
            // straight rows and columns never step on the minor axis
            smi_zero   <= rmaj ? (dc == '0) : (dr == '0);
            ma1        <= rmaj ? {2'b00, t_row} : t_col;
            ma         <= (rmaj ? dr[DW-1] : dc[DW-1]) ? ma0 - 1'b1 : ma0 + 1'b1;
            mi         <= rmaj ? f_col : {2'b00, f_row};
            state      <= S_MUL1;
          end
        end
        S_MUL1: begin
          half  <= $signed(AW'(prod));
          full  <= $signed(AW'({prod, 1'b0}));
          state <= S_MUL2;
        end
        S_MUL2: begin
          acc   <= $signed(AW'(prod));
          slope <= $signed(AW'({prod, 1'b0}));
          state <= S_INIT;
        end
        S_INIT: begin
          // start exactly on a corner: take the diagonal at once
          if (step.minor) begin
            mi <= mi_adv;
          end
          acc   <= step.acc;
          state <= S_LOOP;
        end
        S_LOOP: begin
          if (ma == ma1) begin
            vis_res <= 1'b1;
            state   <= S_DONE;
          end else begin
            state <= S_CHK1;
          end
        end
        S_CHK1: begin
          if (blk) begin
            vis_res <= 1'b0;
            state   <= S_DONE;
          end else begin
            acc <= step.acc;
            if (step.extra) begin
              mi    <= mi_adv;
              state <= S_RD2;
            end else begin
              ma <= ma_adv;
              if (step.minor) begin
                mi <= mi_adv;
              end
              state <= S_LOOP;
            end
          end
        end
        S_RD2: begin
          state <= S_CHK2;
        end
        S_CHK2: begin
          if (blk) begin
            vis_res <= 1'b0;
            state   <= S_DONE;
          end else begin
            ma    <= ma_adv;
            state <= S_LOOP;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/glos_chk.sv -----
// Port-level checker for the grid line-of-sight unit, bound to the top level.
`default_nettype none

module glos_chk (
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_ready,
  input logic res_valid,
  input logic res_ready,
  input logic res_visible
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_visible))
    else $error("result dropped or changed while stalled");

  // busy right after taking an item
  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("item taken while previous item in progress");

  // no result can appear in the cycle after an item is taken
  a_no_fast_res: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && !res_valid |=> !res_valid)
    else $error("result appeared too early");

  // a new result comes only from a busy sequencer
  a_res_src: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(!cmd_ready))
    else $error("result without a query in progress");

  // reset leaves the block idle and empty
  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid && cmd_ready)
    else $error("block not idle after reset");

endmodule

bind grid_line_of_sight_unit glos_chk u_glos_chk (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_visible (res.visible)
);

`default_nettype wire
